/* hw/rtl/drp_pkg.sv */
package drp_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 540;
  localparam int SCREEN_HEIGHT = 960;
  localparam int PHYS_HEIGHT   = 540;

  // Field widths
  localparam int OP_W    = 2;
  localparam int FIELD_W = 13;
  localparam int SUM_W   = FIELD_W + 1;
  localparam int COORD_W = 11;
  localparam int KIND_W  = 2;
  localparam int PCT_W   = 7;
  localparam int PCT_CNT = 1 << PCT_W;
  localparam int AREA_W  = 2 * COORD_W;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(60);

  // Input operations
  localparam logic [OP_W-1:0] OP_MARK      = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_FULL = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH     = 2'd2;

  // Refresh kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd2;

  // Classified commands, front to back
  localparam logic [1:0] CMD_NOP   = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_FULL  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         code;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } cmd_t;

  // floor(screen area * pct / 100), used only to build a constant table
  function automatic logic [AREA_W-1:0] thr_entry(input int pct);
    return AREA_W'((SCREEN_WIDTH * SCREEN_HEIGHT * pct) / 100);
  endfunction

endpackage

/* hw/rtl/drp_in_if.sv */
interface drp_in_if;
  import drp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [FIELD_W-1:0] rect_x;
  logic signed [FIELD_W-1:0] rect_y;
  logic signed [FIELD_W-1:0] rect_width;
  logic signed [FIELD_W-1:0] rect_height;

  modport source (output valid, operation, rect_x, rect_y, rect_width, rect_height,
                  input ready);
  modport sink (input valid, operation, rect_x, rect_y, rect_width, rect_height,
                output ready);
endinterface

/* hw/rtl/drp_out_if.sv */
interface drp_out_if;
  import drp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  refresh_kind;
  logic [COORD_W-1:0] phys_x;
  logic [COORD_W-1:0] phys_y;
  logic [COORD_W-1:0] phys_width;
  logic [COORD_W-1:0] phys_height;
  logic               is_dirty;

  modport source (output valid, refresh_kind, phys_x, phys_y, phys_width, phys_height,
                  is_dirty, input ready);
  modport sink (input valid, refresh_kind, phys_x, phys_y, phys_width, phys_height,
                is_dirty, output ready);
endinterface

/* hw/rtl/dirty_region_refresh_planner_unit.sv */
// Dirty region refresh planner.
// in_ch carries one item per handshake: operation (mark rectangle, mark
// whole screen, flush) and a signed logical rectangle. out_ch returns exactly
// one item for every input item, in order: refresh kind, the partial refresh
// rectangle in physical coordinates (zero unless partial) and the dirty flag.
// cfg_we/cfg_wdata write the full refresh percentage (reset value 60); write
// it only while no item is in flight.
// Throughput: one item per cycle while out_ch.ready is high. An accepted item
// is written into the queue, then loaded into the output register when the
// back end takes it, and its result is offered from then on. The per-cycle
// limit is the back end's state update, one min/max merge or one 11x11 area
// multiply and compare.
// The front end clips and classifies, then hands off through a two-entry
// queue; the back end owns the box state and the output register.
// Reset (rst_n low, synchronous): clean region, no forced refresh, empty
// queue, out_ch.valid low, percentage back to 60.
// When the receiver stalls, the output register holds its item, the queue
// fills, and in_ch.ready drops once two items are waiting.
module dirty_region_refresh_planner_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  drp_in_if.sink                    in_ch,
  drp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [drp_pkg::PCT_W-1:0] cfg_wdata
);
  import drp_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic front_valid, front_ready;
  logic head_valid, head_ready;

  // Front end: clip the rectangle and classify the item
  drp_front u_front (
    .in_ch      (in_ch),
    .push_ready (front_ready),
    .push_valid (front_valid),
    .push_cmd   (front_cmd)
  );

  // Decoupling queue between front and back
  drp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_cmd    (head_cmd)
  );

  // Back end: box state, refresh decision, output register
  drp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (head_valid),
    .cmd_ready (head_ready),
    .cmd       (head_cmd),
    .out_ch    (out_ch)
  );

  // A refresh always comes from a flush, which leaves the region clean
  a_refresh_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.refresh_kind != KIND_NONE)) |-> !out_ch.is_dirty)
    else $error("refresh reported with region still dirty");

  // A partial refresh covers a non-empty rectangle
  a_partial_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.refresh_kind == KIND_PARTIAL)) |->
      ((out_ch.phys_width != '0) && (out_ch.phys_height != '0)))
    else $error("partial refresh with empty rectangle");

  // Anything but a partial refresh carries a zero rectangle
  a_zero_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.refresh_kind != KIND_PARTIAL)) |->
      ((out_ch.phys_x == '0) && (out_ch.phys_y == '0) &&
       (out_ch.phys_width == '0) && (out_ch.phys_height == '0)))
    else $error("rectangle reported without partial refresh");

  // An item taken by the back end leaves a result presented on out_ch
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_ready && head_valid) |=> out_ch.valid)
    else $error("item taken by back end but no result presented");

endmodule

/* hw/rtl/drp_front.sv */
module drp_front (
  drp_in_if.sink         in_ch,
  input  logic           push_ready,
  output logic           push_valid,
  output drp_pkg::cmd_t  push_cmd
);
  import drp_pkg::*;

  localparam logic signed [SUM_W-1:0] SW_S = SUM_W'(SCREEN_WIDTH);
  localparam logic signed [SUM_W-1:0] SH_S = SUM_W'(SCREEN_HEIGHT);

  logic signed [SUM_W-1:0] x_s, y_s, r_s, b_s;
  logic signed [SUM_W-1:0] l_c, t_c, r_c, b_c;
  logic                    w_pos, h_pos, rect_ok;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    x_s = SUM_W'(in_ch.rect_x);
    y_s = SUM_W'(in_ch.rect_y);
    r_s = x_s + SUM_W'(in_ch.rect_width);
    b_s = y_s + SUM_W'(in_ch.rect_height);

    // clip to the screen
    l_c = x_s[SUM_W-1] ? '0 : x_s;
    t_c = y_s[SUM_W-1] ? '0 : y_s;
    r_c = (r_s > SW_S) ? SW_S : r_s;
    b_c = (b_s > SH_S) ? SH_S : b_s;

    w_pos   = !in_ch.rect_width[FIELD_W-1] && (in_ch.rect_width != '0);
    h_pos   = !in_ch.rect_height[FIELD_W-1] && (in_ch.rect_height != '0);
    rect_ok = w_pos && h_pos && (l_c < r_c) && (t_c < b_c);

    push_cmd.left   = COORD_W'(l_c);
    push_cmd.top    = COORD_W'(t_c);
    push_cmd.right  = COORD_W'(r_c);
    push_cmd.bottom = COORD_W'(b_c);

    case (in_ch.operation)
      OP_MARK:      push_cmd.code = rect_ok ? CMD_MARK : CMD_NOP;
      OP_MARK_FULL: push_cmd.code = CMD_FULL;
      OP_FLUSH:     push_cmd.code = CMD_FLUSH;
      default:      push_cmd.code = CMD_NOP;
    endcase
  end

endmodule

/* hw/rtl/drp_queue.sv */
module drp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  drp_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output drp_pkg::cmd_t pop_cmd
);
  import drp_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/drp_back.sv */
module drp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [drp_pkg::PCT_W-1:0] cfg_wdata,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  drp_pkg::cmd_t             cmd,
  drp_out_if.source                 out_ch
);
  import drp_pkg::*;

  localparam logic [COORD_W-1:0] SW_C = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] SH_C = COORD_W'(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] PH_C = COORD_W'(PHYS_HEIGHT);

  logic [AREA_W-1:0]  thr_tbl [PCT_CNT];
  logic [AREA_W-1:0]  thr_r;

  logic [COORD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [COORD_W-1:0] left_nxt, top_nxt, right_nxt, bottom_nxt;
  logic               dirty_r, dirty_nxt, force_r, force_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt, pw_r, pw_nxt, ph_r, ph_nxt;
  logic               od_r, od_nxt;

  logic               fire;
  logic [COORD_W-1:0] bw, bh;
  logic [AREA_W-1:0]  area;
  logic               go_full;

  for (genvar g = 0; g < PCT_CNT; g++) begin : g_thr
    assign thr_tbl[g] = thr_entry(g);
  end

  assign cmd_ready = !out_valid_r || out_ch.ready;
  assign fire      = cmd_valid && cmd_ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.refresh_kind = kind_r;
  assign out_ch.phys_x       = px_r;
  assign out_ch.phys_y       = py_r;
  assign out_ch.phys_width   = pw_r;
  assign out_ch.phys_height  = ph_r;
  assign out_ch.is_dirty     = od_r;

  always_comb begin
    bw      = right_r - left_r;
    bh      = bottom_r - top_r;
    area    = {{COORD_W{1'b0}}, bw} * {{COORD_W{1'b0}}, bh};
    go_full = force_r || (area >= thr_r);

    left_nxt   = left_r;
    top_nxt    = top_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    dirty_nxt  = dirty_r;
    force_nxt  = force_r;
    kind_nxt   = KIND_NONE;
    px_nxt     = '0;
    py_nxt     = '0;
    pw_nxt     = '0;
    ph_nxt     = '0;

    case (cmd.code)
      CMD_MARK: begin
        if (!dirty_r) begin
          left_nxt   = cmd.left;
          top_nxt    = cmd.top;
          right_nxt  = cmd.right;
          bottom_nxt = cmd.bottom;
        end else begin
          if (cmd.left < left_r)     left_nxt   = cmd.left;
          if (cmd.top < top_r)       top_nxt    = cmd.top;
          if (cmd.right > right_r)   right_nxt  = cmd.right;
          if (cmd.bottom > bottom_r) bottom_nxt = cmd.bottom;
        end
        dirty_nxt = 1'b1;
      end
      CMD_FULL: begin
        left_nxt   = '0;
        top_nxt    = '0;
        right_nxt  = SW_C;
        bottom_nxt = SH_C;
        dirty_nxt  = 1'b1;
        force_nxt  = 1'b1;
      end
      CMD_FLUSH: begin
        if (dirty_r) begin
          if (go_full) begin
            kind_nxt = KIND_FULL;
          end else begin
            // transpose, mirror x against the physical height
            kind_nxt = KIND_PARTIAL;
            px_nxt   = top_r;
            py_nxt   = (right_r > PH_C) ? '0 : PH_C - right_r;
            pw_nxt   = bh;
            ph_nxt   = bw;
          end
          dirty_nxt = 1'b0;
          force_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    od_nxt = dirty_nxt;

    out_valid_nxt = fire ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= thr_tbl[PCT_RESET];
      left_r      <= '0;
      top_r       <= '0;
      right_r     <= '0;
      bottom_r    <= '0;
      dirty_r     <= 1'b0;
      force_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= thr_tbl[cfg_wdata];
      end
      if (fire) begin
        left_r   <= left_nxt;
        top_r    <= top_nxt;
        right_r  <= right_nxt;
        bottom_r <= bottom_nxt;
        dirty_r  <= dirty_nxt;
        force_r  <= force_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r <= kind_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pw_r   <= pw_nxt;
      ph_r   <= ph_nxt;
      od_r   <= od_nxt;
    end
  end

endmodule
